FILE: rtl/core/pbts_pkg.sv
// shared types and constants for the page boundary transfer splitter
package pbts_pkg;

  localparam int unsigned MAX_CHUNKS_DEF = 64;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned CLEN_W  = 17;
  localparam int unsigned SHIFT_W = 5;

  localparam int unsigned IN_W  = 96;
  localparam int unsigned OUT_W = 232;

  localparam logic [ADDR_W-1:0]  RESET_BASE  = 64'h0;
  localparam logic [ADDR_W-1:0]  RESET_LIMIT = 64'h0000_8000_0000_0000;
  localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd12;
  localparam logic [SHIFT_W-1:0] MIN_SHIFT   = 5'd12;
  localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 5'd16;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WIN_BASE   = 2'd0;
  localparam cfg_idx_t REG_WIN_LIMIT  = 2'd1;
  localparam cfg_idx_t REG_PAGE_SHIFT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_END   = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

endpackage

FILE: rtl/core/page_boundary_transfer_splitter_top.sv
// page boundary transfer splitter: window check, page range and per-page chunks
// a start-window error or zero length is reported after the window compares, an end
// error after the end compare; chunks follow the page count check, one chunk per cycle while the output is not stalled
// no new request is taken until the last result is registered; the shared 65-bit add/subtract
// unit serves the window and end checks, the range and page count math and the chunk address walk
// reset: synchronous, active high; clears control and restores the window registers
module page_boundary_transfer_splitter_top #(
  parameter int unsigned MAX_CHUNKS = pbts_pkg::MAX_CHUNKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // start_addr[63:0], length[95:64]
  input  logic [pbts_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status[1:0], chunk_addr[65:2], page_offset[81:66], chunk_len[98:82],
  // range_start[162:99], range_end[226:163], zero[231:227]
  output logic [pbts_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                     m_axis_tlast,
  input  logic                     cfg_we,
  input  pbts_pkg::cfg_idx_t       cfg_index,
  input  logic [pbts_pkg::ADDR_W-1:0] cfg_data
);
  import pbts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP_BASE,
    S_CMP_LIM,
    S_ADD_END,
    S_CMP_END,
    S_ROUND,
    S_DEC_END,
    S_DIFF,
    S_CHK_PAGES,
    S_EMIT,
    S_CHUNK
  } state_t;

  state_t state;

  logic [ADDR_W-1:0]  win_base;
  logic [ADDR_W-1:0]  win_limit;
  logic [SHIFT_W-1:0] page_shift;

  logic [ADDR_W-1:0]  start;
  logic [LEN_W-1:0]   len;
  logic [SHIFT_W-1:0] sh;
  logic               ge_base;
  logic               wrap;
  logic [ADDR_W-1:0]  end_addr;
  logic [ADDR_W-1:0]  re;
  logic [ADDR_W-1:0]  diff;
  logic [ADDR_W-1:0]  virt;
  logic [LEN_W-1:0]   rem;
  status_t            pend_status;

  status_t            o_status;
  logic [ADDR_W-1:0]  o_addr;
  logic [OFF_W-1:0]   o_off;
  logic [CLEN_W-1:0]  o_len;
  logic [ADDR_W-1:0]  o_rs;
  logic [ADDR_W-1:0]  o_re;
  logic               o_last;
  logic               o_valid;

  // shared add/subtract unit
  logic [ADDR_W-1:0] alu_a;
  logic [ADDR_W-1:0] alu_b;
  logic              alu_sub;
  logic [ADDR_W:0]   alu_sum;

  logic [SHIFT_W-1:0] sh_eff;
  logic [ADDR_W-1:0]  mask;
  logic [ADDR_W-1:0]  rs;
  logic [CLEN_W-1:0]  psize;
  logic [OFF_W-1:0]   off;
  logic [CLEN_W-1:0]  room;
  logic [CLEN_W-1:0]  c;
  logic [LEN_W-1:0]   rem_left;
  logic               out_free;
  logic               emit_fire;

  assign sh_eff = (page_shift < MIN_SHIFT) ? MIN_SHIFT :
                  (page_shift > MAX_SHIFT) ? MAX_SHIFT : page_shift;

  assign mask     = (ADDR_W'(1) << sh) - ADDR_W'(1);
  assign rs       = start & ~mask;
  assign psize    = CLEN_W'(1) << sh;
  assign off      = virt[OFF_W-1:0] & mask[OFF_W-1:0];
  assign room     = psize - {1'b0, off};
  assign c        = ({{(LEN_W-CLEN_W){1'b0}}, room} > rem) ? rem[CLEN_W-1:0] : room;
  assign rem_left = rem - {{(LEN_W-CLEN_W){1'b0}}, c};
  assign out_free = !o_valid || m_axis_tready;
  assign emit_fire = out_free && ((state == S_EMIT) || (state == S_CHUNK));

  always_comb begin
    alu_a   = start;
    alu_b   = win_base;
    alu_sub = 1'b1;
    case (state)
      S_CMP_BASE: begin
        alu_a = start;
        alu_b = win_base;
      end
      S_CMP_LIM: begin
        alu_a = start;
        alu_b = win_limit;
      end
      S_ADD_END: begin
        alu_a   = start;
        alu_b   = {{(ADDR_W-LEN_W){1'b0}}, len};
        alu_sub = 1'b0;
      end
      S_CMP_END: begin
        alu_a = win_limit;
        alu_b = end_addr;
      end
      S_ROUND: begin
        alu_a   = end_addr;
        alu_b   = mask;
        alu_sub = 1'b0;
      end
      S_DEC_END: begin
        alu_a = end_addr;
        alu_b = ADDR_W'(1);
      end
      S_DIFF: begin
        alu_a = end_addr >> sh;
        alu_b = start >> sh;
      end
      S_CHUNK: begin
        alu_a   = virt;
        alu_b   = {{(ADDR_W-CLEN_W){1'b0}}, c};
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = start;
        alu_b   = win_base;
        alu_sub = 1'b1;
      end
    endcase
    // carry out set on a subtract means no borrow
    alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{ADDR_W{1'b0}}, alu_sub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      o_valid    <= 1'b0;
      win_base   <= RESET_BASE;
      win_limit  <= RESET_LIMIT;
      page_shift <= RESET_SHIFT;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIN_BASE:   win_base   <= cfg_data;
          REG_WIN_LIMIT:  win_limit  <= cfg_data;
          REG_PAGE_SHIFT: page_shift <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (emit_fire) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            start <= s_axis_tdata[ADDR_W-1:0];
            len   <= s_axis_tdata[ADDR_W+LEN_W-1:ADDR_W];
            sh    <= sh_eff;
            state <= S_CMP_BASE;
          end
        end
        S_CMP_BASE: begin
          ge_base <= alu_sum[ADDR_W];
          state   <= S_CMP_LIM;
        end
        S_CMP_LIM: begin
          // an empty window fails here too
          if (!ge_base || alu_sum[ADDR_W]) begin
            pend_status <= ST_BAD_START;
            state       <= S_EMIT;
          end else if (len == '0) begin
            pend_status <= ST_OK;
            state       <= S_EMIT;
          end else begin
            state <= S_ADD_END;
          end
        end
        S_ADD_END: begin
          end_addr <= alu_sum[ADDR_W-1:0];
          wrap     <= alu_sum[ADDR_W];
          state    <= S_CMP_END;
        end
        S_CMP_END: begin
          if (wrap || !alu_sum[ADDR_W]) begin
            pend_status <= ST_BAD_END;
            state       <= S_EMIT;
          end else begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          // range end wraps modulo 2^64
          re    <= alu_sum[ADDR_W-1:0] & ~mask;
          state <= S_DEC_END;
        end
        S_DEC_END: begin
          end_addr <= alu_sum[ADDR_W-1:0];
          state    <= S_DIFF;
        end
        S_DIFF: begin
          diff  <= alu_sum[ADDR_W-1:0];
          state <= S_CHK_PAGES;
        end
        S_CHK_PAGES: begin
          if (diff >= ADDR_W'(MAX_CHUNKS)) begin
            pend_status <= ST_TOO_LONG;
            state       <= S_EMIT;
          end else begin
            virt  <= start;
            rem   <= len;
            state <= S_CHUNK;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_status <= pend_status;
            o_last   <= 1'b1;
            o_len    <= '0;
            case (pend_status)
              ST_OK: begin
                // zero length request
                o_addr <= start;
                o_off  <= start[OFF_W-1:0] & mask[OFF_W-1:0];
                o_rs   <= start;
                o_re   <= start;
              end
              ST_TOO_LONG: begin
                o_addr <= '0;
                o_off  <= '0;
                o_rs   <= rs;
                o_re   <= re;
              end
              default: begin
                o_addr <= '0;
                o_off  <= '0;
                o_rs   <= '0;
                o_re   <= '0;
              end
            endcase
            state <= S_IDLE;
          end
        end
        S_CHUNK: begin
          if (out_free) begin
            o_status <= ST_OK;
            o_addr   <= virt;
            o_off    <= off;
            o_len    <= c;
            o_rs     <= rs;
            o_re     <= re;
            o_last   <= (rem_left == '0);
            virt     <= alu_sum[ADDR_W-1:0];
            rem      <= rem_left;
            if (rem_left == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {{(OUT_W-227){1'b0}}, o_re, o_rs, o_len, o_off, o_addr, o_status};

endmodule
